// ===== rtl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, status codes and length helpers for the MIDI message assembler.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_MTC        = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_UNDEF_A    = 8'hF4;
    localparam logic [7:0] ST_UNDEF_B    = 8'hF5;
    localparam logic [7:0] ST_TUNE       = 8'hF6;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_SENSE      = 8'hFE;
    localparam logic [3:0] HI_PROG       = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;

    localparam int MAX_EMIT = 32;

    // controller to datapath
    typedef struct packed {
        logic take;     // latch the input word
        logic eval;     // parse step, context update, first buffer write
        logic write2;   // data byte after a running-status byte
        logic rd;       // issue buffer read of the current byte
        logic load;     // move read data into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic second;     // a second buffer write is needed
        logic emit;       // this word completes a visible message
        logic emit_held;  // registered emit, used after the second write
        logic out_free;   // output register can take a word
        logic last_byte;  // current read is the final byte of the run
    } status_t;

    function automatic logic [1:0] channel_size(input logic [7:0] status);
        logic [3:0] hi;
        hi = status[7:4];
        if (hi == HI_PROG || hi == HI_PRESSURE) begin
            channel_size = 2'd2;
        end else begin
            channel_size = 2'd3;
        end
    endfunction

    // zero means the byte is dropped
    function automatic logic [1:0] system_length(input logic [7:0] status);
        logic [1:0] len;
        len = 2'd0;
        if (status >= ST_CLOCK) begin
            len = 2'd1;
        end else begin
            case (status)
                ST_MTC:      len = 2'd2;
                ST_SONG_SEL: len = 2'd2;
                ST_SONG_POS: len = 2'd3;
                ST_TUNE:     len = 2'd1;
                ST_EOX:      len = 2'd1;
                default:     len = 2'd0;
            endcase
        end
        system_length = len;
    endfunction

endpackage

// ===== rtl/mma_ram.sv =====
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mma_ctrl.sv =====
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: accept, parse, optional second write, then read out the message.
// ----------------------------------------------------------------------------
module mma_ctrl
    import mma_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_WRITE2 = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (status.second) begin
                    state_next = S_WRITE2;
                end else if (status.emit) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WRITE2: begin
                cmd.write2 = 1'b1;
                state_next = status.emit_held ? S_RD : S_IDLE;
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // read data holds in the ram register until the output frees up
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = status.last_byte ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mma_datapath.sv =====
// ----------------------------------------------------------------------------
// mma_datapath
// Per-cable parser contexts, message buffer and output register.
// ----------------------------------------------------------------------------
module mma_datapath
    import mma_pkg::*;
#(
    parameter int CABLES       = 16,
    parameter int BUFFER_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [3:0]  in_cable,
    input  logic [7:0]  in_byte,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  out_cable,
    output logic [7:0]  out_msg_byte,
    output logic [4:0]  out_byte_index,
    output logic [5:0]  out_msg_length,
    output logic        out_last
);

    localparam int CIDX_W = (CABLES > 1) ? $clog2(CABLES) : 1;
    localparam int POS_W  = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_W  = $clog2(BUFFER_BYTES);
    localparam int DEPTH  = CABLES * BUFFER_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    // parser contexts, one per cable
    logic [POS_W-1:0] pos_reg [CABLES];
    logic [POS_W-1:0] len_reg [CABLES];
    logic             sx_reg  [CABLES];
    logic [7:0]       rs_reg  [CABLES];

    logic [3:0]        cable_reg;
    logic [7:0]        byte_reg;
    logic              hide_reg;
    logic [5:0]        n_reg;
    logic [4:0]        k_reg;
    logic              emit_reg;

    logic              out_valid_reg;
    logic [3:0]        out_cable_reg;
    logic [7:0]        out_byte_reg;
    logic [4:0]        out_index_reg;
    logic [5:0]        out_length_reg;
    logic              out_last_reg;

    logic              cable_ok;
    logic [CIDX_W-1:0] cidx;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  cur_len;
    logic              cur_sx;
    logic [7:0]        cur_rs;

    logic [POS_W-1:0]  nxt_pos;
    logic [POS_W-1:0]  nxt_len;
    logic              nxt_sx;
    logic [7:0]        nxt_rs;
    logic              upd;
    logic              wr_first;
    logic [OFF_W-1:0]  wr_off;
    logic [7:0]        wr_data;
    logic              second;
    logic              overflow;
    logic              complete;
    logic              hidden;
    logic [5:0]        n_calc;

    logic [ADDR_W-1:0] base_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              last_byte;

    assign cable_ok  = (32'(cable_reg) < CABLES);
    assign cidx      = cable_reg[CIDX_W-1:0];
    assign cur_pos   = pos_reg[cidx];
    assign cur_len   = len_reg[cidx];
    assign cur_sx    = sx_reg[cidx];
    assign cur_rs    = rs_reg[cidx];
    assign base_addr = ADDR_W'(cidx) * ADDR_W'(BUFFER_BYTES);

    always_comb begin
        nxt_pos  = cur_pos;
        nxt_len  = cur_len;
        nxt_sx   = cur_sx;
        nxt_rs   = cur_rs;
        upd      = 1'b0;
        wr_first = 1'b0;
        wr_off   = cur_pos[OFF_W-1:0];
        wr_data  = byte_reg;
        second   = 1'b0;
        if (cable_ok) begin
            if (cur_pos == '0) begin
                upd    = 1'b1;
                nxt_sx = 1'b0;
                if (!byte_reg[7]) begin
                    // data byte opens a message under running status
                    if (cur_rs != 8'h00) begin
                        wr_first = 1'b1;
                        wr_off   = '0;
                        wr_data  = cur_rs;
                        second   = 1'b1;
                        nxt_pos  = POS_W'(2);
                        nxt_len  = POS_W'(channel_size(cur_rs));
                    end
                end else if (byte_reg < ST_SYSEX) begin
                    wr_first = 1'b1;
                    wr_off   = '0;
                    nxt_pos  = POS_W'(1);
                    nxt_len  = POS_W'(channel_size(byte_reg));
                    nxt_rs   = byte_reg;
                end else if (byte_reg == ST_SYSEX) begin
                    wr_first = 1'b1;
                    wr_off   = '0;
                    nxt_pos  = POS_W'(1);
                    nxt_len  = '0;
                    nxt_sx   = 1'b1;
                end else if (byte_reg != ST_UNDEF_A && byte_reg != ST_UNDEF_B) begin
                    wr_first = 1'b1;
                    wr_off   = '0;
                    nxt_pos  = POS_W'(1);
                    nxt_len  = POS_W'(system_length(byte_reg));
                end
            end else if (!byte_reg[7] || (byte_reg == ST_EOX && cur_sx)) begin
                upd      = 1'b1;
                wr_first = (32'(cur_pos) < BUFFER_BYTES);
                nxt_pos  = cur_pos + POS_W'(1);
                if (byte_reg[7]) begin
                    nxt_sx  = 1'b0;
                    nxt_len = cur_pos + POS_W'(1);
                end
            end
        end
        overflow = nxt_sx && (32'(nxt_pos) >= BUFFER_BYTES);
        complete = upd && !overflow && (nxt_len != '0) && (nxt_pos >= nxt_len);
        if (overflow) begin
            nxt_pos = '0;
            nxt_len = '0;
            nxt_sx  = 1'b0;
        end
        if (complete) begin
            nxt_pos = '0;
        end
        hidden = hide_reg && (cur_pos == '0) &&
                 (byte_reg == ST_CLOCK || byte_reg == ST_SENSE);
        if (32'(nxt_len) > MAX_EMIT) begin
            n_calc = 6'(MAX_EMIT);
        end else begin
            n_calc = 6'(nxt_len);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CABLES; i++) begin
                pos_reg[i] <= '0;
                len_reg[i] <= '0;
                sx_reg[i]  <= 1'b0;
                rs_reg[i]  <= 8'h00;
            end
            hide_reg <= 1'b1;
            emit_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                hide_reg <= cfg_data;
            end
            if (cmd.eval) begin
                emit_reg <= complete && !hidden;
                if (upd) begin
                    pos_reg[cidx] <= nxt_pos;
                    len_reg[cidx] <= nxt_len;
                    sx_reg[cidx]  <= nxt_sx;
                    rs_reg[cidx]  <= nxt_rs;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            cable_reg <= in_cable;
            byte_reg  <= in_byte;
        end
        if (cmd.eval) begin
            n_reg <= n_calc;
            k_reg <= '0;
        end else if (cmd.load) begin
            k_reg <= k_reg + 5'd1;
        end
    end

    // buffer: single write port, registered read
    assign ram_we    = (cmd.eval && wr_first) || cmd.write2;
    assign ram_waddr = base_addr + ADDR_W'(cmd.write2 ? OFF_W'(1) : wr_off);
    assign ram_wdata = cmd.write2 ? byte_reg : wr_data;
    assign ram_raddr = base_addr + ADDR_W'(k_reg);

    mma_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign last_byte = (({1'b0, k_reg} + 6'd1) == n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_cable_reg  <= cable_reg;
            out_byte_reg   <= ram_rdata;
            out_index_reg  <= k_reg;
            out_length_reg <= n_reg;
            out_last_reg   <= last_byte;
        end
    end

    assign status.second    = second;
    assign status.emit      = complete && !hidden;
    assign status.emit_held = emit_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_byte = last_byte;

    assign out_valid      = out_valid_reg;
    assign out_cable      = out_cable_reg;
    assign out_msg_byte   = out_byte_reg;
    assign out_byte_index = out_index_reg;
    assign out_msg_length = out_length_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== rtl/midi_message_assembler.sv =====
// A completing byte is parsed and written to the message buffer (a data byte under
// running status takes a second write), then read out word by word through the
// registered buffer read into the output register. A new byte is accepted only once
// the previous one is parsed and its message read out; the single-port message buffer
// and its registered read set the pace, and a low m_tready stalls the read-out.
// Reset: all cable contexts cleared, clock/sensing hiding on; the buffer is not cleared.
// ----------------------------------------------------------------------------
// midi_message_assembler
// Per-cable MIDI parser with running status; emits each message as a run of words.
// ----------------------------------------------------------------------------
module midi_message_assembler
    import mma_pkg::*;
#(
    parameter int CABLES       = 16,
    parameter int BUFFER_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] midi_byte
    input  logic [3:0]  s_tuser,    // [3:0] cable
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] msg_byte, [12:8] byte_index,
                                    // [18:13] msg_length, [23:19] zero
    output logic [3:0]  m_tuser,    // [3:0] out_cable
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data    // hide_clock_messages
);

    cmd_t       cmd;
    status_t    status;
    logic [7:0] msg_byte;
    logic [4:0] byte_index;
    logic [5:0] msg_length;

    mma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mma_datapath #(
        .CABLES       (CABLES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_cable       (s_tuser),
        .in_byte        (s_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_cable      (m_tuser),
        .out_msg_byte   (msg_byte),
        .out_byte_index (byte_index),
        .out_msg_length (msg_length),
        .out_last       (m_tlast)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, msg_length, byte_index, msg_byte};

endmodule

// ===== rtl/mma_checker.sv =====
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks on the assembler's output word stream.
// ----------------------------------------------------------------------------
module mma_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // last flag sits exactly on the final position of the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (({1'b0, m_tdata[12:8]} + 6'd1) == m_tdata[18:13])))
        else $error("last flag does not match index and length");

    // every message opens with a status byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:8] == 5'd0) |-> m_tdata[7])
        else $error("first word of a message is not a status byte");

endmodule

bind midi_message_assembler mma_checker u_mma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/midi_message_assembler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_assembler_tb
// Feeds tagged MIDI bytes through the stream input, rebuilds every emitted
// message with a per-cable parser of its own and compares each output word
// field by field, across both settings of the clock/sensing hiding flag.
// ----------------------------------------------------------------------------
module midi_message_assembler_tb;
    import mma_pkg::*;

    localparam int CABLES       = 16;
    localparam int BUF_BYTES    = 32;
    localparam int MAX_WORDS    = 32;
    localparam int TAIL_CYCLES  = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 55;
    localparam int DATA_MAX     = 127;

    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_CONTROL  = 4'hB;
    localparam logic [3:0] HI_PITCH    = 4'hE;
    localparam logic [7:0] ST_RESET    = 8'hFF;

    typedef struct packed {
        logic [3:0] cable;
        logic [7:0] data;
    } midi_in_t;

    typedef struct packed {
        logic [3:0] cable;
        logic [7:0] data;
        logic [4:0] idx;
        logic [5:0] len;
        logic       last;
    } midi_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] midi_byte
    logic [3:0]  s_tuser;     // [3:0] cable
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] msg_byte, [12:8] byte_index, [18:13] msg_length
    logic [3:0]  m_tuser;     // [3:0] out_cable
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // parser contexts of the predictor
    logic [5:0]  ctx_pos [CABLES];
    logic [5:0]  ctx_len [CABLES];
    logic        ctx_sysex [CABLES];
    logic [7:0]  ctx_run [CABLES];
    logic [7:0]  ctx_buf [CABLES][BUF_BYTES];
    logic        hide_timing;

    midi_in_t    byte_queue[$];
    midi_word_t  pending_words[$];
    bit          offered;
    bit          steady;
    bit          hold_rx;
    int          hold_count;
    int          idle_cycles;
    int          mismatches;

    midi_message_assembler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int chan_len(input logic [7:0] st);
        return (st[7:4] == HI_PROG || st[7:4] == HI_PRESSURE) ? 2 : 3;
    endfunction

    function automatic midi_in_t mk(input logic [3:0] c, input logic [7:0] b);
        midi_in_t m;
        m.cable = c;
        m.data  = b;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (mismatches < 50) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got_v, want_v);
        end
        mismatches++;
    endtask

    // advance one cable's parser by one byte, queue the words of a finished message
    task automatic assemble_byte(input logic [3:0] c, input logic [7:0] b);
        int p;
        int l;
        int n;
        midi_word_t w;
        p = ctx_pos[c];
        l = 0;
        if (p == 0) begin
            ctx_sysex[c] = 1'b0;
            if (!b[7]) begin
                if (ctx_run[c] == 8'h00) return;
                ctx_buf[c][0] = ctx_run[c];
                ctx_buf[c][1] = b;
                p = 2;
                l = chan_len(ctx_run[c]);
            end else if (b < ST_SYSEX) begin
                ctx_buf[c][0] = b;
                p = 1;
                l = chan_len(b);
                ctx_run[c] = b;
            end else if (b == ST_SYSEX) begin
                ctx_buf[c][0] = b;
                p = 1;
                l = 0;
                ctx_sysex[c] = 1'b1;
            end else if (b < ST_CLOCK) begin
                case (b)
                    ST_MTC, ST_SONG_SEL: l = 2;
                    ST_SONG_POS:         l = 3;
                    ST_TUNE, ST_EOX:     l = 1;
                    default:             return;
                endcase
                ctx_buf[c][0] = b;
                p = 1;
            end else begin
                ctx_buf[c][0] = b;
                p = 1;
                l = 1;
            end
            ctx_pos[c] = 6'(p);
            ctx_len[c] = 6'(l);
        end else begin
            if (!b[7]) begin
                if (p < BUF_BYTES) ctx_buf[c][p] = b;
                p++;
            end else if (b == ST_EOX && ctx_sysex[c]) begin
                if (p < BUF_BYTES) ctx_buf[c][p] = b;
                p++;
                ctx_sysex[c] = 1'b0;
                ctx_len[c] = 6'(p);
            end else begin
                return;
            end
            // sysex that fills the buffer without its end byte is thrown away
            if (ctx_sysex[c] && p >= BUF_BYTES) begin
                ctx_pos[c]   = '0;
                ctx_len[c]   = '0;
                ctx_sysex[c] = 1'b0;
                return;
            end
            ctx_pos[c] = 6'(p);
            l = ctx_len[c];
        end
        if (l == 0 || p < l) return;
        ctx_pos[c] = '0;
        if (hide_timing && (ctx_buf[c][0] == ST_CLOCK || ctx_buf[c][0] == ST_SENSE)) return;
        n = (l > MAX_WORDS) ? MAX_WORDS : l;
        for (int k = 0; k < n; k++) begin
            w.cable = c;
            w.data  = (k < BUF_BYTES) ? ctx_buf[c][k] : 8'h00;
            w.idx   = 5'(k);
            w.len   = 6'(n);
            w.last  = (k + 1 == n);
            pending_words.push_back(w);
        end
    endtask

    // sampling side: results first, then config and input words
    always @(posedge aclk) begin
        midi_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("word with nothing pending", int'(m_tdata), 0);
                end else begin
                    want = pending_words.pop_front();
                    if (m_tuser !== want.cable)
                        report_mismatch("out_cable", int'(m_tuser), int'(want.cable));
                    if (m_tdata[7:0] !== want.data)
                        report_mismatch("msg_byte", int'(m_tdata[7:0]), int'(want.data));
                    if (m_tdata[12:8] !== want.idx)
                        report_mismatch("byte_index", int'(m_tdata[12:8]), int'(want.idx));
                    if (m_tdata[18:13] !== want.len)
                        report_mismatch("msg_length", int'(m_tdata[18:13]), int'(want.len));
                    if (m_tlast !== want.last)
                        report_mismatch("last", int'(m_tlast), int'(want.last));
                end
            end
            if (cfg_valid && cfg_ready) hide_timing = cfg_data;
            if (s_tvalid && s_tready) begin
                assemble_byte(s_tuser, s_tdata);
                byte_queue.delete(0);
                offered = 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("midi_message_assembler_tb: errors");
                $finish;
            end
        end
    end

    // byte driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!offered) begin
            if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue[0].data;
                s_tuser  <= byte_queue[0].cable;
                offered = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_rx && hold_count < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_count++;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    task automatic push_byte(input logic [3:0] c, input logic [7:0] b);
        byte_queue.push_back(mk(c, b));
    endtask

    task automatic write_hide(input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || offered || pending_words.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic make_message(input logic [3:0] c, output midi_in_t seq[$], output bit noise);
        int kind;
        int n;
        int pos;
        logic [7:0] st;
        seq = {};
        noise = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            st = {4'($urandom_range(HI_NOTE_OFF, HI_PITCH)), 4'($urandom_range(0, 15))};
            seq.push_back(mk(c, st));
            repeat (chan_len(st) - 1) seq.push_back(mk(c, 8'($urandom_range(0, DATA_MAX))));
        end else if (kind < 55) begin
            // data only, rides on whatever running status the cable holds
            repeat ($urandom_range(1, 2)) seq.push_back(mk(c, 8'($urandom_range(0, DATA_MAX))));
        end else if (kind < 65) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 31) : $urandom_range(0, 6);
            seq.push_back(mk(c, ST_SYSEX));
            repeat (n) seq.push_back(mk(c, 8'($urandom_range(0, DATA_MAX))));
            seq.push_back(mk(c, ST_EOX));
        end else if (kind < 78) begin
            case ($urandom_range(0, 6))
                0: seq = '{mk(c, ST_MTC), mk(c, 8'($urandom_range(0, DATA_MAX)))};
                1: seq = '{mk(c, ST_SONG_SEL), mk(c, 8'($urandom_range(0, DATA_MAX)))};
                2: seq = '{mk(c, ST_SONG_POS), mk(c, 8'($urandom_range(0, DATA_MAX))),
                           mk(c, 8'($urandom_range(0, DATA_MAX)))};
                3: seq = '{mk(c, ST_TUNE)};
                4: seq = '{mk(c, ST_EOX)};
                5: seq = '{mk(c, ST_UNDEF_A)};
                default: seq = '{mk(c, ST_UNDEF_B)};
            endcase
        end else if (kind < 88) begin
            seq.push_back(mk(c, 8'($urandom_range(ST_CLOCK, ST_RESET))));
        end else begin
            noise = 1'b1;
            repeat ($urandom_range(1, 3)) seq.push_back(mk(c, 8'($urandom_range(0, 255))));
        end
        if (!noise && seq.size() > 1 && $urandom_range(0, 99) < 15) begin
            pos = $urandom_range(1, seq.size() - 1);
            seq.insert(pos, mk(c, 8'($urandom_range(ST_CLOCK, ST_RESET))));
        end
        // cut short now and then so the next status lands mid-message
        if (!noise && seq.size() > 1 && $urandom_range(0, 99) < 8) seq.delete(seq.size() - 1);
    endtask

    task automatic run_random(input int budget);
        midi_in_t a[$];
        midi_in_t b[$];
        bit na;
        bit nb;
        int got;
        logic [3:0] ca;
        got = 0;
        while (got < budget) begin
            // mostly a few cables so running status gets reused
            ca = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
            make_message(ca, a, na);
            b = {};
            nb = 1'b1;
            if ($urandom_range(0, 99) < 30) make_message(ca ^ 4'($urandom_range(1, 15)), b, nb);
            if (!na) got += a.size();
            if (!nb) got += b.size();
            while (a.size() != 0 || b.size() != 0) begin
                if (b.size() == 0 || (a.size() != 0 && $urandom_range(0, 1) == 1)) begin
                    byte_queue.push_back(a.pop_front());
                end else begin
                    byte_queue.push_back(b.pop_front());
                end
            end
        end
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        offered     = 1'b0;
        steady      = 1'b0;
        hold_rx     = 1'b0;
        hold_count  = 0;
        idle_cycles = 0;
        mismatches  = 0;
        hide_timing = 1'b1;
        for (int c = 0; c < CABLES; c++) begin
            ctx_pos[c]   = '0;
            ctx_len[c]   = '0;
            ctx_sysex[c] = 1'b0;
            ctx_run[c]   = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_hide(1'b1);
        // note on with its two data bytes, then two more data bytes under running status
        push_byte(4'd0, {HI_NOTE_ON, 4'h0});
        push_byte(4'd0, 8'h3C);
        push_byte(4'd0, 8'h7F);
        push_byte(4'd0, 8'h3C);
        push_byte(4'd0, 8'h00);
        push_byte(4'd15, {HI_PROG, 4'hF});
        push_byte(4'd15, 8'h7F);
        // stray data byte on a cable with no running status
        push_byte(4'd3, 8'h12);
        push_byte(4'd1, ST_UNDEF_A);
        push_byte(4'd1, ST_UNDEF_B);
        push_byte(4'd1, ST_EOX);
        push_byte(4'd2, ST_SONG_POS);
        push_byte(4'd2, 8'h7F);
        push_byte(4'd2, 8'h7F);
        push_byte(4'd2, ST_TUNE);
        push_byte(4'd4, ST_CLOCK);
        push_byte(4'd4, ST_SENSE);
        push_byte(4'd5, ST_SYSEX);
        push_byte(4'd5, 8'h01);
        push_byte(4'd5, ST_EOX);
        // realtime and a channel status inside a message are both skipped
        push_byte(4'd6, {HI_CONTROL, 4'h0});
        push_byte(4'd6, 8'h40);
        push_byte(4'd6, ST_RESET);
        push_byte(4'd6, {HI_NOTE_OFF, 4'h0});
        push_byte(4'd6, 8'h41);
        wait_idle();

        write_hide(1'b0);
        run_random(PHASE_ITEMS);
        wait_idle();

        write_hide(1'b1);
        hold_rx = 1'b1;
        run_random(PHASE_ITEMS);
        wait_idle();

        write_hide(1'b0);
        steady = 1'b1;
        run_random(PHASE_ITEMS);
        wait_idle();

        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("midi_message_assembler_tb: clean");
        end else begin
            $display("midi_message_assembler_tb: errors");
        end
        $finish;
    end

endmodule
